>>> rtl/core/pscu_pkg.sv
// Package for the packed single compare unit: operation and predicate codes,
// lane count and the per-lane compare result struct. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package pscu_pkg;
    localparam int LANES = 8;
    localparam int LANE_W = 32;

    typedef enum logic [1:0] {
        OP_CMP  = 2'd0,
        OP_MIN  = 2'd1,
        OP_MAX  = 2'd2,
        OP_SCMP = 2'd3
    } t_op;

    localparam logic [3:0] P_EQ_OQ = 4'd0,  P_LT_OS = 4'd1,  P_LE_OS = 4'd2,
                           P_UNORD = 4'd3,  P_NEQ_UQ = 4'd4, P_NLT = 4'd5,
                           P_NLE = 4'd6,    P_ORD = 4'd7,    P_EQ_UQ = 4'd8,
                           P_NGE = 4'd9,    P_NGT = 4'd10,   P_FALSE = 4'd11,
                           P_NEQ_OQ = 4'd12, P_GE = 4'd13,   P_GT = 4'd14,
                           P_TRUE = 4'd15;

    // compare relation of one lane pair
    typedef struct packed {
        logic nan;
        logic eq;
        logic lt;
        logic gt;
    } t_rel;

    localparam logic [2:0] FLAGS_UNORD = 3'b111;
    localparam logic [2:0] FLAGS_GT    = 3'b000;
    localparam logic [2:0] FLAGS_LT    = 3'b001;
    localparam logic [2:0] FLAGS_EQ    = 3'b100;
endpackage
`default_nettype wire

>>> rtl/core/pscu_lane.sv
// One compare lane: relation of two singles and the lane result for compare,
// min and max. Uses pscu_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pscu_lane import pscu_pkg::*; (
    input  wire logic [1:0]        i_op,
    input  wire logic [3:0]        i_pred,
    input  wire logic [LANE_W-1:0] i_a,
    input  wire logic [LANE_W-1:0] i_b,
    output logic [LANE_W-1:0]      o_res,
    output t_rel                   o_rel
);
    logic        a_nan, b_nan, nan, eq, lt, gt, hit, take_b;
    logic [31:0] ka, kb, za, zb;

    always_comb begin
        a_nan = (i_a[30:23] == 8'hff) && (i_a[22:0] != 23'd0);
        b_nan = (i_b[30:23] == 8'hff) && (i_b[22:0] != 23'd0);
        nan = a_nan | b_nan;
        za = (i_a[30:0] == 31'd0) ? 32'd0 : i_a;
        zb = (i_b[30:0] == 31'd0) ? 32'd0 : i_b;
        // sign-magnitude to monotone unsigned key
        ka = za[31] ? ~za : (za | 32'h8000_0000);
        kb = zb[31] ? ~zb : (zb | 32'h8000_0000);
        eq = !nan && (ka == kb);
        lt = !nan && (ka < kb);
        gt = !nan && !eq && !lt;
        case (i_pred)
            P_EQ_OQ:  hit = eq;
            P_LT_OS:  hit = lt;
            P_LE_OS:  hit = lt | eq;
            P_UNORD:  hit = nan;
            P_NEQ_UQ: hit = !eq;
            P_NLT:    hit = nan | gt | eq;
            P_NLE:    hit = nan | gt;
            P_ORD:    hit = !nan;
            P_EQ_UQ:  hit = eq | nan;
            P_NGE:    hit = lt | nan;
            P_NGT:    hit = lt | eq | nan;
            P_FALSE:  hit = 1'b0;
            P_NEQ_OQ: hit = !nan && !eq;
            P_GE:     hit = gt | eq;
            P_GT:     hit = gt;
            default:  hit = 1'b1;
        endcase
        take_b = (i_op == OP_MIN) ? (nan || kb <= ka) : (nan || kb >= ka);
        if (i_op == OP_CMP) begin
            o_res = hit ? 32'hffff_ffff : 32'd0;
        end else begin
            o_res = take_b ? i_b : i_a;
        end
        o_rel = '{nan: nan, eq: eq, lt: lt, gt: gt};
    end
endmodule
`default_nettype wire

>>> rtl/core/pscu_merge.sv
// Merge stage: gathers lane results, applies 128-bit zeroing and scalar
// flags, registers the word with a skid-free output register. Uses pscu_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pscu_merge import pscu_pkg::*; (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_load,
    input  wire logic                    i_unload,
    input  wire logic [1:0]              i_op,
    input  wire logic                    i_wide,
    input  wire logic [LANES*LANE_W-1:0] i_res,
    input  wire t_rel                    i_rel0,
    output logic                         o_valid,
    output logic [LANES*LANE_W-1:0]      o_res,
    output logic [2:0]                   o_flags
);
    logic [LANES*LANE_W-1:0] n_res;
    logic [2:0]              n_flags;
    logic                    r_valid;
    logic [LANES*LANE_W-1:0] r_res;
    logic [2:0]              r_flags;

    always_comb begin
        n_res = i_res;
        n_flags = 3'd0;
        if (i_op == OP_SCMP) begin
            n_res = '0;
            if (i_rel0.nan)     n_flags = FLAGS_UNORD;
            else if (i_rel0.gt) n_flags = FLAGS_GT;
            else if (i_rel0.lt) n_flags = FLAGS_LT;
            else                n_flags = FLAGS_EQ;
        end else if (!i_wide) begin
            n_res[LANES*LANE_W-1:LANES*LANE_W/2] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_unload) begin
            r_valid <= 1'b0;
        end
        if (i_load) begin
            r_res <= n_res;
            r_flags <= n_flags;
        end
    end

    assign o_valid = r_valid;
    assign o_res = r_res;
    assign o_flags = r_flags;
endmodule
`default_nettype wire

>>> rtl/core/packed_single_compare_unit.sv
// Packed single compare unit: result word in the cycle after acceptance, one
// word per cycle unless the output stalls; eight parallel lanes feed one merge
// register. A new word is taken whenever the output register is empty or
// being drained the same cycle. Synchronous active-low reset empties the
// output register. Uses pscu_pkg, pscu_lane, pscu_merge.
`timescale 1ns / 1ps
`default_nettype none
module packed_single_compare_unit import pscu_pkg::*; (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // [1:0] operation, [5:2] predicate, [6] wide, [70:7] first_lanes_0_1,
    // [134:71] first_lanes_2_3, [198:135] first_lanes_4_5,
    // [262:199] first_lanes_6_7, [326:263] second_lanes_0_1,
    // [390:327] second_lanes_2_3, [454:391] second_lanes_4_5,
    // [518:455] second_lanes_6_7, [527:519] zero
    input  wire logic [527:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // [63:0] result_lanes_0_1, [127:64] result_lanes_2_3,
    // [191:128] result_lanes_4_5, [255:192] result_lanes_6_7,
    // [258:256] compare_flags, [263:259] zero
    output logic [263:0]      m_axis_tdata
);
    logic [1:0]              op;
    logic [3:0]              pred;
    logic [LANES*LANE_W-1:0] src_a, src_b, lane_res;
    t_rel                    rel [LANES];
    logic [2:0]              flags;
    logic [LANES*LANE_W-1:0] res;
    logic                    load, unload;

    assign op = s_axis_tdata[1:0];
    assign pred = s_axis_tdata[5:2];
    assign src_a = s_axis_tdata[262:7];
    assign src_b = s_axis_tdata[518:263];
    assign unload = m_axis_tvalid & m_axis_tready;
    assign s_axis_tready = !m_axis_tvalid | m_axis_tready;
    assign load = s_axis_tvalid & s_axis_tready;

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        pscu_lane u_lane (
            .i_op  (op),
            .i_pred(pred),
            .i_a   (src_a[g*LANE_W +: LANE_W]),
            .i_b   (src_b[g*LANE_W +: LANE_W]),
            .o_res (lane_res[g*LANE_W +: LANE_W]),
            .o_rel (rel[g])
        );
    end

    pscu_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (load),
        .i_unload(unload),
        .i_op    (op),
        .i_wide  (s_axis_tdata[6]),
        .i_res   (lane_res),
        .i_rel0  (rel[0]),
        .o_valid (m_axis_tvalid),
        .o_res   (res),
        .o_flags (flags)
    );

    assign m_axis_tdata = {5'd0, flags, res};
endmodule
`default_nettype wire

>>> rtl/core/pscu_checker.sv
// Port-level assertions for packed_single_compare_unit, bound to the top level.
// Uses pscu_pkg and the top-level ports.
`timescale 1ns / 1ps
`default_nettype none
module pscu_assertions import pscu_pkg::*; (
    input wire logic         i_clk,
    input wire logic         i_rst_n,
    input wire logic         s_axis_tvalid,
    input wire logic         s_axis_tready,
    input wire logic [527:0] s_axis_tdata,
    input wire logic         m_axis_tvalid,
    input wire logic         m_axis_tready,
    input wire logic [263:0] m_axis_tdata
);
    // a word accepted always shows up next cycle
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
        else $error("accepted word not presented");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("stalled while output empty");
    a_scmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tdata[1:0] == OP_SCMP
        |=> m_axis_tdata[255:0] == '0 && m_axis_tdata[258:256] != 3'b010)
        else $error("scalar compare result malformed");
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tdata[1:0] != OP_SCMP
        |=> m_axis_tdata[258:256] == 3'd0)
        else $error("flags set outside scalar compare");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output word changed under stall");
endmodule

bind packed_single_compare_unit pscu_assertions u_pscu_assertions (.*);
`default_nettype wire

>>> sim/pscu_checker.sv
// Checker for the packed single compare unit: watches both stream channels,
// predicts each result word from the accepted input word and compares it.
// Depends on pscu_pkg.
`timescale 1ns / 1ps
module pscu_checker import pscu_pkg::*; (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    input  wire logic         s_axis_tready,
    input  wire logic [527:0] s_axis_tdata,
    input  wire logic         m_axis_tvalid,
    input  wire logic         m_axis_tready,
    input  wire logic [263:0] m_axis_tdata,
    output int                o_errors,
    output int                o_pending
);
    typedef struct packed {
        logic [2:0]  flags;
        logic [63:0] l67;
        logic [63:0] l45;
        logic [63:0] l23;
        logic [63:0] l01;
    } t_result;

    t_result expected_words[$];

    function automatic logic lane_is_nan(logic [31:0] x);
        return x[30:23] == 8'hff && x[22:0] != 0;
    endfunction

    // monotone key; both zeros map to the same key
    function automatic logic [31:0] sort_key(logic [31:0] x);
        logic [31:0] v;
        v = (x[30:0] == 0) ? 32'd0 : x;
        return v[31] ? ~v : (v | 32'h8000_0000);
    endfunction

    function automatic logic pred_holds(logic [3:0] p, logic [31:0] a, logic [31:0] b);
        logic n, eq, lt, gt;
        n  = lane_is_nan(a) || lane_is_nan(b);
        eq = !n && sort_key(a) == sort_key(b);
        lt = !n && sort_key(a) < sort_key(b);
        gt = !n && sort_key(a) > sort_key(b);
        case (p)
            P_EQ_OQ:  return eq;
            P_LT_OS:  return lt;
            P_LE_OS:  return lt || eq;
            P_UNORD:  return n;
            P_NEQ_UQ: return !eq;
            P_NLT:    return n || gt || eq;
            P_NLE:    return n || gt;
            P_ORD:    return !n;
            P_EQ_UQ:  return eq || n;
            P_NGE:    return lt || n;
            P_NGT:    return lt || eq || n;
            P_FALSE:  return 1'b0;
            P_NEQ_OQ: return !n && !eq;
            P_GE:     return gt || eq;
            P_GT:     return gt;
            default:  return 1'b1;
        endcase
    endfunction

    function automatic t_result compute_result(logic [527:0] w);
        t_op         op;
        logic [3:0]  p;
        logic        wide;
        logic [255:0] va, vb, r;
        logic [31:0] a, b;
        logic        n, take_b;
        t_result     res;
        op   = t_op'(w[1:0]);
        p    = w[5:2];
        wide = w[6];
        va   = w[262:7];
        vb   = w[518:263];
        r    = '0;
        res  = '0;
        if (op == OP_SCMP) begin
            a = va[31:0];
            b = vb[31:0];
            if (lane_is_nan(a) || lane_is_nan(b)) res.flags = FLAGS_UNORD;
            else if (sort_key(a) > sort_key(b)) res.flags = FLAGS_GT;
            else if (sort_key(a) < sort_key(b)) res.flags = FLAGS_LT;
            else res.flags = FLAGS_EQ;
            return res;
        end
        for (int i = 0; i < LANES; i++) begin
            if (i < 4 || wide) begin
                a = va[i*32 +: 32];
                b = vb[i*32 +: 32];
                if (op == OP_CMP) begin
                    r[i*32 +: 32] = pred_holds(p, a, b) ? 32'hffff_ffff : 32'h0;
                end else begin
                    n = lane_is_nan(a) || lane_is_nan(b);
                    take_b = (op == OP_MIN) ? (n || sort_key(b) <= sort_key(a))
                                            : (n || sort_key(b) >= sort_key(a));
                    r[i*32 +: 32] = take_b ? b : a;
                end
            end
        end
        {res.l67, res.l45, res.l23, res.l01} = r;
        return res;
    endfunction

    assign o_pending = expected_words.size();

    always @(posedge i_clk) begin
        t_result got, want;
        if (!i_rst_n) begin
            o_errors <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                expected_words.push_back(compute_result(s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready) begin
                got = t_result'(m_axis_tdata[258:0]);
                if (expected_words.size() == 0) begin
                    $error("result word with nothing expected: %h", m_axis_tdata);
                    o_errors <= o_errors + 1;
                end else begin
                    want = expected_words.pop_front();
                    if (got != want || m_axis_tdata[263:259] != 0) begin
                        o_errors <= o_errors + 1;
                        if (got.l01 != want.l01)
                            $error("result_lanes_0_1 exp %h got %h", want.l01, got.l01);
                        if (got.l23 != want.l23)
                            $error("result_lanes_2_3 exp %h got %h", want.l23, got.l23);
                        if (got.l45 != want.l45)
                            $error("result_lanes_4_5 exp %h got %h", want.l45, got.l45);
                        if (got.l67 != want.l67)
                            $error("result_lanes_6_7 exp %h got %h", want.l67, got.l67);
                        if (got.flags != want.flags)
                            $error("compare_flags exp %h got %h", want.flags, got.flags);
                        if (m_axis_tdata[263:259] != 0)
                            $error("pad exp 0 got %h", m_axis_tdata[263:259]);
                    end
                end
            end
        end
    end
endmodule

>>> sim/packed_single_compare_unit_test.sv
// Testbench top for the packed single compare unit: drives directed and random
// compare/min/max/scalar words with random gaps and stalls; verdict from pscu_checker.
// Depends on pscu_pkg, packed_single_compare_unit, pscu_checker.
`timescale 1ns / 1ps
module packed_single_compare_unit_test;
    import pscu_pkg::*;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [527:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [263:0] m_axis_tdata;
    int           n_errors;
    int           n_pending;
    int           cycle_count = 0;

    localparam int CYCLE_LIMIT = 200000;

    packed_single_compare_unit u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    pscu_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .o_errors(n_errors), .o_pending(n_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // singles biased toward zeros, infinities, NaNs, ties and near neighbors
    function automatic logic [31:0] pick_single(logic [31:0] other);
        logic [31:0] s;
        s = $urandom;
        case ($urandom_range(0, 11))
            0: s = {s[31], 31'h0};
            1: s = {s[31], 8'hff, 23'h0};
            2: s = {s[31], 8'hff, s[22:0] | 23'h1};
            3: s = other;
            4: s = {~other[31], other[30:0]};
            5: s = other + 32'd1;
            6: s = {s[31], 8'h00, s[22:0]};
            7: s = {s[31], 8'h7f + s[3:0], s[22:0]};
            default: ;
        endcase
        return s;
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_word(t_op op, logic [3:0] p, logic wide,
                             logic [255:0] va, logic [255:0] vb);
        int g;
        g = gap_len();
        repeat (g) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {9'd0, vb, va, wide, p, op};
        // ready is settled shortly after the falling edge until the next rising edge
        #1;
        while (!s_axis_tready) begin
            @(negedge i_clk);
            #1;
        end
        @(negedge i_clk);
    endtask

    task automatic send_random(t_op op, logic [3:0] p, logic wide);
        logic [255:0] va, vb;
        for (int i = 0; i < 8; i++) begin
            va[i*32 +: 32] = pick_single(32'h3f80_0000);
            vb[i*32 +: 32] = pick_single(va[i*32 +: 32]);
        end
        send_word(op, p, wide, va, vb);
    endtask

    initial begin
        logic [255:0] va, vb;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        // each predicate over lanes covering NaN, both zeros, infinities, ties
        va = {32'h7fc0_0000, 32'h0000_0000, 32'h7f80_0000, 32'h3f80_0000,
              32'hbf80_0000, 32'h8000_0000, 32'h4000_0000, 32'hffff_ffff};
        vb = {32'h3f80_0000, 32'h8000_0000, 32'h7f80_0000, 32'h3f80_0000,
              32'hff80_0000, 32'h0000_0000, 32'h3f80_0000, 32'h0000_0001};
        for (int p = 0; p < 16; p++) send_word(OP_CMP, p[3:0], 1'b1, va, vb);
        send_word(OP_MIN, 4'hf, 1'b1, va, vb);
        send_word(OP_MAX, 4'h0, 1'b1, va, vb);
        send_word(OP_MIN, 4'h0, 1'b0, vb, va);
        send_word(OP_CMP, P_TRUE, 1'b0, '1, '1);
        send_word(OP_MAX, 4'h5, 1'b1, '1, '0);
        send_word(OP_SCMP, 4'h0, 1'b1, va, vb);           // unordered
        send_word(OP_SCMP, 4'h0, 1'b0, {8{32'h0}}, {8{32'h8000_0000}}); // equal
        send_word(OP_SCMP, 4'h3, 1'b1, {8{32'hbf80_0000}}, vb); // less
        send_word(OP_SCMP, 4'h9, 1'b0, {8{32'h7f80_0000}}, vb); // greater

        // drain before random traffic
        s_axis_tvalid <= 1'b0;
        while (n_pending != 0) @(negedge i_clk);

        for (int n = 0; n < 400; n++) begin
            send_random(t_op'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                        1'($urandom_range(0, 1)));
            if (n % 100 == 99) begin
                s_axis_tvalid <= 1'b0;
                while (n_pending != 0) @(negedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b0;
        while (n_pending != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
        if (n_errors == 0) $display("No mismatches found");
        else $display("Mismatches found");
        $finish;
    end

    // receiver stalls: phases of always-ready alternate with random stalls
    initial begin
        int g;
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (cycle_count % 800 < 200) begin
                m_axis_tready <= 1'b1;
            end else begin
                g = gap_len();
                if (g == 0) begin
                    m_axis_tready <= 1'b1;
                end else begin
                    m_axis_tready <= 1'b0;
                    repeat (g) @(negedge i_clk);
                    m_axis_tready <= 1'b1;
                end
            end
        end
    end
endmodule

>>> filelist.f
rtl/core/pscu_pkg.sv
rtl/core/pscu_lane.sv
rtl/core/pscu_merge.sv
rtl/core/packed_single_compare_unit.sv
rtl/core/pscu_checker.sv
sim/pscu_checker.sv
sim/packed_single_compare_unit_test.sv
